### rtl/dbll_pkg.sv
// Shared constants, types and helpers for the bounded doubly linked list unit.
package dbll_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int LCNT_W   = 5;
	localparam int STATUS_W = 2;
	// wide enough to compare a position against a count plus one
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef enum logic [FUNC_W-1:0] {
		FN_INS_HEAD = 3'd0,
		FN_INS_TAIL = 3'd1,
		FN_INS_POS  = 3'd2,
		FN_DEL_HEAD = 3'd3,
		FN_DEL_TAIL = 3'd4,
		FN_DEL_POS  = 3'd5,
		FN_READ     = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_BAD_POS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_DELETE,
		CMD_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t        cmd;
		logic [IDX_W-1:0] idx;
	} chain_ctrl_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	function automatic logic [LCNT_W-1:0] to_list_count(logic [CNT_W-1:0] c);
		logic [CMP_W-1:0] w;
		w = CMP_W'(c);
		return w[LCNT_W-1:0];
	endfunction

endpackage

### rtl/dbll_req_if.sv
// Request channel: operation selector, value and position.
interface dbll_req_if;
	import dbll_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [FUNC_W-1:0]         func;
	logic signed [VALUE_W-1:0] item_value;
	logic [POS_W-1:0]          position;

	modport source (output valid, func, item_value, position, input ready);
	modport sink   (input valid, func, item_value, position, output ready);
endinterface

### rtl/dbll_rsp_if.sv
// Result channel: value, flags, status and list count.
interface dbll_rsp_if;
	import dbll_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] result_value;
	logic                      has_value;
	logic [STATUS_W-1:0]       status;
	logic [LCNT_W-1:0]         list_count;
	logic                      is_last;

	modport source (output valid, result_value, has_value, status, list_count, is_last,
		input ready);
	modport sink   (input valid, result_value, has_value, status, list_count, is_last,
		output ready);
endinterface

### rtl/dbll_cell.sv
// One list cell: holds the value at its list position and shifts with its neighbours.
module dbll_cell (
	input  logic                          clk,
	input  logic [dbll_pkg::IDX_W-1:0]    cell_idx,
	input  dbll_pkg::chain_ctrl_t         ctrl,
	input  dbll_pkg::value_t              new_value,
	input  dbll_pkg::value_t              head_value,
	input  dbll_pkg::value_t              left_value,
	input  dbll_pkg::value_t              right_value,
	output dbll_pkg::value_t              value
);
	import dbll_pkg::*;

	value_t value_q;
	value_t value_d;

	always_comb begin
		value_d = value_q;
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (cell_idx == ctrl.idx) begin
					value_d = new_value;
				end else if (cell_idx > ctrl.idx) begin
					value_d = left_value;
				end
			end
			CMD_DELETE: begin
				if (cell_idx >= ctrl.idx) begin
					value_d = right_value;
				end
			end
			CMD_ROTATE: begin
				// idx marks the tail cell; it takes the old head
				if (cell_idx == ctrl.idx) begin
					value_d = head_value;
				end else if (cell_idx < ctrl.idx) begin
					value_d = right_value;
				end
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;

endmodule

### rtl/dbll_chain.sv
// Row of list cells, cell 0 holding the head.
module dbll_chain (
	input  logic                     clk,
	input  dbll_pkg::chain_ctrl_t    ctrl,
	input  dbll_pkg::value_t         new_value,
	output dbll_pkg::value_t         values [dbll_pkg::CAPACITY]
);
	import dbll_pkg::*;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		value_t left_v;
		value_t right_v;

		if (i == 0) begin : g_first
			assign left_v = new_value;
		end else begin : g_mid_l
			assign left_v = values[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = values[0];
		end else begin : g_mid_r
			assign right_v = values[i+1];
		end

		dbll_cell u_cell (
			.clk        (clk),
			.cell_idx   (IDX_W'(i)),
			.ctrl       (ctrl),
			.new_value  (new_value),
			.head_value (values[0]),
			.left_value (left_v),
			.right_value(right_v),
			.value      (values[i])
		);
	end

endmodule

### rtl/bounded_doubly_linked_list_unit.sv
// Handshake: an insert, delete or flagged request is taken when ready is high; its result is
//   registered and offered in the cycle after it is taken.
// Throughput: while the result side keeps taking, one such request per cycle; a read out
//   holds off requests until its last value is loaded, one per cycle by cell-row rotation.
// Reset: arst_n clears the count, the controller state and the output valid at once; the
//   cell contents are left as they are and are never read before being written.
module bounded_doubly_linked_list_unit (
	input logic         clk,
	input logic         arst_n,
	dbll_req_if.sink    req,
	dbll_rsp_if.source  rsp
);
	import dbll_pkg::*;

	// Controller and list occupancy
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [CNT_W-1:0]   rd_q, rd_d;     // readout progress

	// Output register
	logic               rsp_valid_q;
	value_t             result_value_q;
	logic               has_value_q;
	status_t            status_q;
	logic [LCNT_W-1:0]  list_count_q;
	logic               is_last_q;

	// Load of the output register this cycle
	logic               load;
	value_t             ld_value;
	logic               ld_has;
	status_t            ld_status;
	logic               ld_last;

	logic               out_free;
	logic               full;
	logic               empty;
	logic [CMP_W-1:0]   pos_x;
	logic [CMP_W-1:0]   cnt_x;
	logic               ins_pos_ok;
	logic               del_pos_ok;

	chain_ctrl_t        ctrl;
	value_t             cell_values [CAPACITY];

	// The list lives in a row of cells in list order: cell k holds position k+1.
	// Inserts shift the cells behind the position one place back, deletes pull them
	// forward, and a read out rotates the occupied cells once round.
	dbll_chain u_chain (
		.clk      (clk),
		.ctrl     (ctrl),
		.new_value(req.item_value),
		.values   (cell_values)
	);

	// The output register may be reloaded when empty or being drained this cycle
	assign out_free = !rsp_valid_q || rsp.ready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	// Position checks in a width that holds count plus one
	assign pos_x      = CMP_W'(req.position);
	assign cnt_x      = CMP_W'(count_q);
	assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
	assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		rd_d      = rd_q;
		ctrl      = '{cmd: CMD_HOLD, idx: '0};
		load      = 1'b0;
		ld_value  = '0;
		ld_has    = 1'b0;
		ld_status = ST_OK;
		ld_last   = 1'b1;
		req.ready = 1'b0;

		case (state_q)
			S_IDLE: begin
				req.ready = out_free;
				if (req.valid && out_free) begin
					case (func_t'(req.func))
						FN_INS_HEAD, FN_INS_TAIL, FN_INS_POS: begin
							load = 1'b1;
							// full check takes precedence over the position check
							if (full) begin
								ld_status = ST_FULL;
							end else if (func_t'(req.func) == FN_INS_POS && !ins_pos_ok) begin
								ld_status = ST_BAD_POS;
							end else begin
								ctrl.cmd = CMD_INSERT;
								case (func_t'(req.func))
									FN_INS_HEAD: ctrl.idx = '0;
									FN_INS_TAIL: ctrl.idx = IDX_W'(count_q);
									default:     ctrl.idx = IDX_W'(pos_x - 1'b1);
								endcase
								count_d = count_q + 1'b1;
							end
						end
						FN_DEL_HEAD, FN_DEL_TAIL, FN_DEL_POS: begin
							load = 1'b1;
							if (empty) begin
								ld_status = ST_EMPTY;
							end else if (func_t'(req.func) == FN_DEL_POS && !del_pos_ok) begin
								ld_status = ST_BAD_POS;
							end else begin
								ctrl.cmd = CMD_DELETE;
								case (func_t'(req.func))
									FN_DEL_HEAD: ctrl.idx = '0;
									FN_DEL_TAIL: ctrl.idx = IDX_W'(count_q - 1'b1);
									default:     ctrl.idx = IDX_W'(pos_x - 1'b1);
								endcase
								// removed value is taken before the row shifts
								ld_value = cell_values[ctrl.idx];
								ld_has   = 1'b1;
								count_d  = count_q - 1'b1;
							end
						end
						FN_READ: begin
							if (empty) begin
								load      = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								state_d = S_READ;
								rd_d    = '0;
							end
						end
						default: begin
							// unused selector: no change, plain ok result
							load = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					// head is always in cell 0; rotate the occupied cells by one
					load     = 1'b1;
					ld_value = cell_values[0];
					ld_has   = 1'b1;
					ld_last  = (rd_q == count_q - 1'b1);
					ctrl.cmd = CMD_ROTATE;
					ctrl.idx = IDX_W'(count_q - 1'b1);
					rd_d     = rd_q + 1'b1;
					if (ld_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			rd_q        <= rd_d;
			rsp_valid_q <= load || (rsp_valid_q && !rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_value_q <= ld_value;
			has_value_q    <= ld_has;
			status_q       <= ld_status;
			list_count_q   <= to_list_count(count_d);
			is_last_q      <= ld_last;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_value = result_value_q;
	assign rsp.has_value    = has_value_q;
	assign rsp.status       = status_q;
	assign rsp.list_count   = list_count_q;
	assign rsp.is_last      = is_last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("list count beyond capacity");

	a_read_progress: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> (rd_q < count_q))
		else $error("readout ran past the list end");

	a_no_req_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> !req.ready)
		else $error("request taken during readout");

	a_value_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && has_value_q) |-> (status_q == ST_OK))
		else $error("value carried with a failure status");

	a_empty_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !has_value_q) |-> (result_value_q == '0))
		else $error("non-zero value without has_value");
`endif

endmodule
